### hw/rtl/wav_riff_header_parser_core_assert.svh
// Assertion macros used by the checker file of the WAV header parser.
`ifndef WAV_RIFF_HEADER_PARSER_CORE_ASSERT_SVH
`define WAV_RIFF_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define WRHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define WRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wrhp_pkg.sv
// Types, tags and status codes of the WAV header parser.
package wrhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] HEADER_BYTES = 32'd12;
    localparam logic [31:0] CHUNK_BYTES  = 32'd8;
    localparam logic [31:0] FMT_BYTES    = 32'd16;

    localparam logic [2:0] ST_HEADER = 3'd0;
    localparam logic [2:0] ST_CHUNK  = 3'd1;
    localparam logic [2:0] ST_FMT    = 3'd2;
    localparam logic [2:0] ST_SKIP   = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;
    localparam logic [2:0] ST_NORIFF = 3'd5;
    localparam logic [2:0] ST_NOWAVE = 3'd6;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b000_0001,
        PH_CHUNK  = 7'b000_0010,
        PH_FMT    = 7'b000_0100,
        PH_SKIP   = 7'b000_1000,
        PH_DATA   = 7'b001_0000,
        PH_NORIFF = 7'b010_0000,
        PH_NOWAVE = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic [2:0]  parse_status;
        logic        data_found;
        logic        format_seen;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_result;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        unique case (ph)
            PH_HEADER: code = ST_HEADER;
            PH_CHUNK:  code = ST_CHUNK;
            PH_FMT:    code = ST_FMT;
            PH_SKIP:   code = ST_SKIP;
            PH_DATA:   code = ST_DATA;
            PH_NORIFF: code = ST_NORIFF;
            PH_NOWAVE: code = ST_NOWAVE;
            default:   code = ST_HEADER;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/wrhp_stream_if.sv
// Valid/ready channel interfaces for byte input and parse results.
interface wrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface wrhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  parse_status;
    logic        data_found;
    logic        format_seen;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_offset;
    logic [31:0] data_size;

    modport source (output valid, output parse_status, output data_found,
                    output format_seen, output sample_rate, output bits_per_sample,
                    output data_offset, output data_size, input ready);
    modport sink   (input valid, input parse_status, input data_found,
                    input format_seen, input sample_rate, input bits_per_sample,
                    input data_offset, input data_size, output ready);
endinterface

### hw/rtl/wav_riff_header_parser_core.sv
// Top level of the WAV header parser: input register, parse step, result register.
//
//   channel | dir | payload                                      | handshake
//   i_in    | in  | data_byte[7:0], restart                      | valid/ready
//   o_out   | out | parse_status, data_found, format_seen,       | valid/ready
//           |     | sample_rate, bits_per_sample, data_offset,   |
//           |     | data_size                                    |
//
// One byte word per cycle sustained while the result side is ready; the result passes
// from the input register through the parse step into the result register.
// The state update between the two registers sets the cycle time.
// Reset is synchronous, active low, and returns the parser to the file header.
// A stalled result holds the result register; the input register still takes
// one more byte, after which input ready drops until the result moves.
module wav_riff_header_parser_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrhp_in_if.sink     i_in,
    wrhp_out_if.source  o_out
);
    import wrhp_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_restart;
    logic       out_ready;
    logic       fire;
    t_result    step_result;
    t_result    out_result;

    assign fire = in_valid && out_ready;

    wrhp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_data_byte (i_in.data_byte),
        .i_restart   (i_in.restart),
        .i_take      (out_ready),
        .o_valid     (in_valid),
        .o_data_byte (in_byte),
        .o_restart   (in_restart)
    );

    wrhp_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (in_byte),
        .i_restart   (in_restart),
        .o_result    (step_result)
    );

    wrhp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .o_ready  (out_ready),
        .i_result (step_result),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (out_result)
    );

    assign o_out.parse_status    = out_result.parse_status;
    assign o_out.data_found      = out_result.data_found;
    assign o_out.format_seen     = out_result.format_seen;
    assign o_out.sample_rate     = out_result.sample_rate;
    assign o_out.bits_per_sample = out_result.bits_per_sample;
    assign o_out.data_offset     = out_result.data_offset;
    assign o_out.data_size       = out_result.data_size;
endmodule

### hw/rtl/wrhp_in_reg.sv
// Input register: holds one byte word until the parse step takes it.
module wrhp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_restart
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_restart;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte    <= i_data_byte;
            r_restart <= i_restart;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;
    assign o_restart   = r_restart;
endmodule

### hw/rtl/wrhp_step.sv
// Parser state and the per-byte update that forms one result word.
module wrhp_step #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_data_byte,
    input  logic              i_restart,
    output wrhp_pkg::t_result o_result
);
    import wrhp_pkg::*;

    t_phase                 r_phase, n_phase, b_phase;
    logic [31:0]            r_rem, n_rem, b_rem;
    logic [OFFSET_BITS-1:0] r_off, n_off, b_off;
    logic [31:0]            r_tag, n_tag, b_tag;
    logic [31:0]            r_size, n_size, b_size;
    logic [31:0]            r_rate, n_rate, b_rate;
    logic [15:0]            r_bits, n_bits, b_bits;
    logic                   r_fmt, n_fmt, b_fmt;
    logic [31:0]            r_doff, n_doff, b_doff;
    logic [31:0]            r_dlen, n_dlen, b_dlen;
    logic                   pulse;
    logic [31:0]            hdr_tag;
    logic [31:0]            chk_tag;
    logic [31:0]            chk_size;

    always_comb begin
        // restart byte parses from the reset state
        if (i_restart) begin
            b_phase = PH_HEADER;
            b_rem   = HEADER_BYTES;
            b_off   = '0;
            b_tag   = '0;
            b_size  = '0;
            b_rate  = '0;
            b_bits  = '0;
            b_fmt   = 1'b0;
            b_doff  = '0;
            b_dlen  = '0;
        end else begin
            b_phase = r_phase;
            b_rem   = r_rem;
            b_off   = r_off;
            b_tag   = r_tag;
            b_size  = r_size;
            b_rate  = r_rate;
            b_bits  = r_bits;
            b_fmt   = r_fmt;
            b_doff  = r_doff;
            b_dlen  = r_dlen;
        end

        n_phase = b_phase;
        n_rem   = b_rem;
        n_off   = b_off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        n_tag   = b_tag;
        n_size  = b_size;
        n_rate  = b_rate;
        n_bits  = b_bits;
        n_fmt   = b_fmt;
        n_doff  = b_doff;
        n_dlen  = b_dlen;
        pulse   = 1'b0;

        hdr_tag  = {b_tag[23:0], i_data_byte};
        chk_tag  = (b_rem > 32'd4) ? hdr_tag : b_tag;
        chk_size = (b_rem > 32'd4) ? b_size : {i_data_byte, b_size[31:8]};

        unique case (b_phase)
            PH_HEADER: begin
                n_rem = b_rem - 32'd1;
                n_tag = hdr_tag;
                if (b_rem == 32'd9 && hdr_tag != TAG_RIFF) begin
                    n_phase = PH_NORIFF;
                end else if (b_rem == 32'd1) begin
                    if (hdr_tag != TAG_WAVE) begin
                        n_phase = PH_NOWAVE;
                    end else begin
                        n_phase = PH_CHUNK;
                        n_rem   = CHUNK_BYTES;
                    end
                end
            end
            PH_CHUNK: begin
                n_rem  = b_rem - 32'd1;
                n_tag  = chk_tag;
                n_size = chk_size;
                if (b_rem == 32'd1) begin
                    if (chk_tag == TAG_FMT) begin
                        n_size  = (chk_size > FMT_BYTES) ? chk_size - FMT_BYTES : '0;
                        n_phase = PH_FMT;
                        n_rem   = FMT_BYTES;
                    end else if (chk_tag == TAG_DATA) begin
                        n_dlen  = chk_size;
                        n_doff  = 32'(n_off);
                        n_phase = PH_DATA;
                        pulse   = 1'b1;
                    end else if (chk_size == '0) begin
                        n_phase = PH_CHUNK;
                        n_rem   = CHUNK_BYTES;
                    end else begin
                        n_phase = PH_SKIP;
                        n_rem   = chk_size;
                    end
                end
            end
            PH_FMT: begin
                n_rem = b_rem - 32'd1;
                case (b_rem)
                    32'd12:  n_rate[7:0]   = i_data_byte;
                    32'd11:  n_rate[15:8]  = i_data_byte;
                    32'd10:  n_rate[23:16] = i_data_byte;
                    32'd9:   n_rate[31:24] = i_data_byte;
                    32'd2:   n_bits[7:0]   = i_data_byte;
                    32'd1:   n_bits[15:8]  = i_data_byte;
                    default: ;
                endcase
                if (b_rem == 32'd1) begin
                    n_fmt = 1'b1;
                    if (b_size == '0) begin
                        n_phase = PH_CHUNK;
                        n_rem   = CHUNK_BYTES;
                    end else begin
                        n_phase = PH_SKIP;
                        n_rem   = b_size;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = b_rem - 32'd1;
                if (b_rem == 32'd1) begin
                    n_phase = PH_CHUNK;
                    n_rem   = CHUNK_BYTES;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_rem   <= HEADER_BYTES;
            r_off   <= '0;
            r_tag   <= '0;
            r_size  <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_fmt   <= 1'b0;
            r_doff  <= '0;
            r_dlen  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_off   <= n_off;
            r_tag   <= n_tag;
            r_size  <= n_size;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_fmt   <= n_fmt;
            r_doff  <= n_doff;
            r_dlen  <= n_dlen;
        end
    end

    always_comb begin
        o_result.parse_status    = phase_code(n_phase);
        o_result.data_found      = pulse;
        o_result.format_seen     = n_fmt;
        o_result.sample_rate     = n_rate;
        o_result.bits_per_sample = n_bits;
        o_result.data_offset     = n_doff;
        o_result.data_size       = n_dlen;
    end
endmodule

### hw/rtl/wrhp_out_reg.sv
// Result register: holds one result word until the sink takes it.
module wrhp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wrhp_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output wrhp_pkg::t_result o_result
);
    import wrhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

### hw/rtl/wrhp_checker.sv
// Port-level checker of the WAV header parser, bound to the top level.
`include "wav_riff_header_parser_core_assert.svh"

module wrhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_parse_status,
    input logic        i_data_found,
    input logic [31:0] i_data_size
);
    import wrhp_pkg::*;

    // result word holds while stalled
    `WRHP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_data_size) && $stable(i_parse_status), "result changed while stalled")

    // data pulse only comes with the data status
    `WRHP_ASSERT_IMPL(a_found_status, i_clk, i_rst_n, i_out_valid && i_data_found, i_parse_status == ST_DATA, "data_found without data status")

    // reset empties the result register
    `WRHP_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid, "result valid after reset")
endmodule

bind wav_riff_header_parser_core wrhp_checker u_wrhp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_parse_status (o_out.parse_status),
    .i_data_found   (o_out.data_found),
    .i_data_size    (o_out.data_size)
);

### tb/tb_wav_riff_header_parser_core.sv
// Testbench for the WAV header parser: byte stream stimulus and field-by-field result checks.
`timescale 1ns / 1ps

module tb_wav_riff_header_parser_core;
    import wrhp_pkg::*;

    // Offset counter narrower than the block's default width of 32.
    localparam int          OFFSET_W    = 16;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          HOLD_CYCLES = 64;
    localparam int          TAIL_CYCLES = 8;
    localparam logic [31:0] TAG_LIST    = 32'h4C49_5354;
    localparam logic [31:0] TAG_RIFX    = 32'h5249_4658;
    localparam logic [31:0] TAG_WAVF    = 32'h5741_5646;

    logic i_clk;
    logic i_rst_n;

    wrhp_in_if  in_ch ();
    wrhp_out_if out_ch ();

    wav_riff_header_parser_core #(.OFFSET_BITS(OFFSET_W)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Parser state as predicted from the bytes accepted so far.
    logic [2:0]          ph_state;
    logic [31:0]         bytes_left;
    logic [OFFSET_W-1:0] stream_pos;
    logic [31:0]         tag_shift;
    logic [31:0]         size_shift;
    logic [31:0]         rate_val;
    logic [15:0]         depth_val;
    logic                fmt_done;
    logic [31:0]         payload_at;
    logic [31:0]         payload_len;

    t_result parse_results_q[$];

    int tx_idle_pct;
    int rx_stall_pct;
    bit rx_hold_req;
    int failures;
    int results_checked;
    int found_count;
    int bytes_sent;
    int files_sent;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ph_state    = ST_HEADER;
        bytes_left  = HEADER_BYTES;
        stream_pos  = '0;
        tag_shift   = '0;
        size_shift  = '0;
        rate_val    = '0;
        depth_val   = '0;
        fmt_done    = 1'b0;
        payload_at  = '0;
        payload_len = '0;
    endfunction

    function automatic void open_chunk_header();
        ph_state   = ST_CHUNK;
        bytes_left = CHUNK_BYTES;
    endfunction

    function automatic t_result parse_next_byte(input logic [7:0] b, input logic rs);
        t_result     r;
        logic [31:0] idx;
        logic        pulse;
        pulse = 1'b0;
        if (rs)
            clear_parser();
        stream_pos = stream_pos + OFFSET_W'(1);
        case (ph_state)
            ST_HEADER: begin
                idx        = HEADER_BYTES - bytes_left;
                bytes_left = bytes_left - 1;
                tag_shift  = {tag_shift[23:0], b};
                if (idx == 3 && tag_shift != TAG_RIFF)
                    ph_state = ST_NORIFF;
                else if (idx == 11) begin
                    if (tag_shift != TAG_WAVE)
                        ph_state = ST_NOWAVE;
                    else
                        open_chunk_header();
                end
            end
            ST_CHUNK: begin
                idx        = CHUNK_BYTES - bytes_left;
                bytes_left = bytes_left - 1;
                // tag arrives big-endian, size little-endian
                if (idx < 4)
                    tag_shift = {tag_shift[23:0], b};
                else
                    size_shift = {b, size_shift[31:8]};
                if (bytes_left == 0) begin
                    if (tag_shift == TAG_FMT) begin
                        size_shift = (size_shift > FMT_BYTES) ? size_shift - FMT_BYTES : '0;
                        ph_state   = ST_FMT;
                        bytes_left = FMT_BYTES;
                    end else if (tag_shift == TAG_DATA) begin
                        payload_len = size_shift;
                        payload_at  = 32'(stream_pos);
                        ph_state    = ST_DATA;
                        pulse       = 1'b1;
                    end else if (size_shift == 0) begin
                        open_chunk_header();
                    end else begin
                        ph_state   = ST_SKIP;
                        bytes_left = size_shift;
                    end
                end
            end
            ST_FMT: begin
                idx        = FMT_BYTES - bytes_left;
                bytes_left = bytes_left - 1;
                if (idx >= 4 && idx < 8)
                    rate_val[8*(idx-4) +: 8] = b;
                else if (idx == 14)
                    depth_val[7:0] = b;
                else if (idx == 15)
                    depth_val[15:8] = b;
                if (bytes_left == 0) begin
                    fmt_done = 1'b1;
                    if (size_shift == 0)
                        open_chunk_header();
                    else begin
                        ph_state   = ST_SKIP;
                        bytes_left = size_shift;
                    end
                end
            end
            ST_SKIP: begin
                bytes_left = bytes_left - 1;
                if (bytes_left == 0)
                    open_chunk_header();
            end
            default: ;
        endcase
        r.parse_status    = ph_state;
        r.data_found      = pulse;
        r.format_seen     = fmt_done;
        r.sample_rate     = rate_val;
        r.bits_per_sample = depth_val;
        r.data_offset     = payload_at;
        r.data_size       = payload_len;
        return r;
    endfunction

    // Offer one word, wait for the handshake, then record what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.restart   <= rs;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        parse_results_q.push_back(parse_next_byte(b, rs));
        bytes_sent++;
        if (rs)
            files_sent++;
    endtask

    task automatic send_tag(input logic [31:0] tag, input logic rs);
        send_byte(tag[31:24], rs);
        send_byte(tag[23:16], 1'b0);
        send_byte(tag[15:8], 1'b0);
        send_byte(tag[7:0], 1'b0);
    endtask

    task automatic send_le32(input logic [31:0] v);
        send_byte(v[7:0], 1'b0);
        send_byte(v[15:8], 1'b0);
        send_byte(v[23:16], 1'b0);
        send_byte(v[31:24], 1'b0);
    endtask

    task automatic send_filler(input logic [31:0] n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_header(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
        send_tag(riff_tag, 1'b1);
        send_le32($urandom());
        send_tag(wave_tag, 1'b0);
    endtask

    task automatic send_chunk(input logic [31:0] tag, input logic [31:0] size);
        send_tag(tag, 1'b0);
        send_le32(size);
    endtask

    // fmt chunk: 16 PCM field bytes with random filler, then the declared excess.
    task automatic send_fmt(input logic [31:0] size, input logic [31:0] rate,
                            input logic [15:0] depth);
        logic [7:0] b;
        send_chunk(TAG_FMT, size);
        for (int i = 0; i < 16; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i >= 4 && i < 8)
                b = rate[8*(i-4) +: 8];
            else if (i == 14)
                b = depth[7:0];
            else if (i == 15)
                b = depth[15:8];
            send_byte(b, 1'b0);
        end
        if (size > FMT_BYTES)
            send_filler(size - FMT_BYTES);
    endtask

    // Drop valid and wait out every pending result.
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (parse_results_q.size() != 0);
    endtask

    task automatic send_random_file();
        int          kind;
        int          n;
        logic [31:0] sz;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            send_tag($urandom(), 1'b1);
            send_filler($urandom_range(0, 8));
        end else if (kind == 1) begin
            send_header(TAG_RIFF, $urandom());
            send_filler($urandom_range(0, 6));
        end else if (kind == 2) begin
            n = $urandom_range(1, 20);
            repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (kind == 3) begin
            // cut short: the next file's restart interrupts it
            send_header(TAG_RIFF, TAG_WAVE);
            send_chunk(TAG_FMT, $urandom_range(0, 24));
            send_filler($urandom_range(0, 15));
        end else begin
            send_header(TAG_RIFF, TAG_WAVE);
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0: send_fmt($urandom_range(0, 24), $urandom(), 16'($urandom()));
                    1: begin
                        sz = $urandom_range(0, 10);
                        send_chunk($urandom(), sz);
                        send_filler(sz);
                    end
                    default: send_chunk($urandom(), '0);
                endcase
            end
            case ($urandom_range(0, 3))
                0:       sz = '0;
                1:       sz = '1;
                default: sz = $urandom();
            endcase
            send_chunk(TAG_DATA, sz);
            send_filler($urandom_range(0, 4));
        end
    endtask

    task automatic test_extreme_fields();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_header(TAG_RIFF, TAG_WAVE);
        send_fmt(FMT_BYTES, 32'hFFFF_FFFF, 16'hFFFF);
        send_chunk(TAG_DATA, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_header(TAG_RIFF, TAG_WAVE);
        send_fmt(FMT_BYTES, '0, '0);
        send_chunk(TAG_DATA, '0);
        wait_results_drained();
    endtask

    task automatic test_bad_tags();
        // bad RIFF tag: the WAVE tag that follows must be ignored
        send_tag(TAG_RIFX, 1'b1);
        send_le32('0);
        send_tag(TAG_WAVE, 1'b0);
        send_header(TAG_RIFF, TAG_WAVF);
        send_filler(2);
        wait_results_drained();
    endtask

    task automatic test_chunk_walk();
        send_header(TAG_RIFF, TAG_WAVE);
        send_chunk(TAG_LIST, '0);
        send_fmt(32'd8, 32'd48000, 16'd24);
        send_fmt(32'd20, 32'd44100, 16'd16);
        send_chunk(TAG_LIST, 32'd5);
        send_filler(5);
        send_fmt('0, 32'd96000, 16'd32);
        send_chunk(TAG_DATA, '0);
        send_filler(2);
        // restart in the middle of a fmt body
        send_header(TAG_RIFF, TAG_WAVE);
        send_chunk(TAG_FMT, FMT_BYTES);
        send_filler(6);
        send_header(TAG_RIFF, TAG_WAVE);
        send_chunk(TAG_DATA, 32'd1234);
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        repeat (3) send_random_file();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int tx_pcts [4] = '{0, 80, 0, 16};
        int rx_pcts [4] = '{0, 0, 80, 16};
        int start;
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            start        = bytes_sent;
            while (bytes_sent - start < 25)
                send_random_file();
            wait_results_drained();
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_checked, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (out_ch.data_found === 1'b1)
                found_count++;
            if (parse_results_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result %0d with status %0d",
                             results_checked, out_ch.parse_status);
            end else begin
                want = parse_results_q.pop_front();
                check_field("parse_status", 32'(out_ch.parse_status),
                            32'(want.parse_status));
                check_field("data_found", 32'(out_ch.data_found), 32'(want.data_found));
                check_field("format_seen", 32'(out_ch.format_seen),
                            32'(want.format_seen));
                check_field("sample_rate", out_ch.sample_rate, want.sample_rate);
                check_field("bits_per_sample", 32'(out_ch.bits_per_sample),
                            32'(want.bits_per_sample));
                check_field("data_offset", out_ch.data_offset, want.data_offset);
                check_field("data_size", out_ch.data_size, want.data_size);
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart   = 1'b0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rx_hold_req     = 1'b0;
        failures        = 0;
        results_checked = 0;
        found_count     = 0;
        bytes_sent      = 0;
        files_sent      = 0;
        quiet_cycles    = 0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_fields();
        test_bad_tags();
        test_chunk_walk();
        test_output_backpressure();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        failures += parse_results_q.size();
        $display("run covered %0d files in %0d bytes: bad tags, fmt/skip/data chunks,",
                 files_sent, bytes_sent);
        $display("restarts, long hold-off, stalls; %0d results checked, %0d data hits",
                 results_checked, found_count);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
